// ----- design/ybp_pkg.sv -----
`default_nettype none

package ybp_pkg;

    // Table sizes and field geometry.
    localparam int CHOICE_ENTRIES    = 2048;
    localparam int CACHE_ENTRIES     = 2048;
    localparam int COUNTER_BITS      = 2;
    localparam int THREADS           = 4;
    localparam int INSTRUCTION_SHIFT = 2;
    localparam int TAG_SKIP          = 10;

    localparam int ADDR_W         = 32;
    localparam int ACTION_W       = 3;
    localparam int THREAD_FIELD_W = 2;
    localparam int HIST_FIELD_W   = 11;
    localparam int SOURCE_W       = 2;
    localparam int S_TDATA_W      = 56;
    localparam int M_TDATA_W      = 16;

    localparam int CHOICE_IDX_W = $clog2(CHOICE_ENTRIES);
    localparam int CACHE_IDX_W  = $clog2(CACHE_ENTRIES);
    localparam int SET_W        = CACHE_IDX_W - 1;
    localparam int HIST_W       = CACHE_IDX_W;
    localparam int TAG_W        = ADDR_W - INSTRUCTION_SHIFT - TAG_SKIP;
    localparam int TID_W        = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int CLR_W        = (CHOICE_IDX_W > CACHE_IDX_W) ? CHOICE_IDX_W : CACHE_IDX_W;

    // Result queue geometry.
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_LOOKUP  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_UNCOND  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_UPDATE  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RESTORE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_BTB_MISS = 3'd4;

    // Prediction source codes.
    localparam logic [SOURCE_W-1:0] SRC_CHOICE    = 2'd0;
    localparam logic [SOURCE_W-1:0] SRC_TAKEN     = 2'd1;
    localparam logic [SOURCE_W-1:0] SRC_NOT_TAKEN = 2'd2;

    typedef logic [COUNTER_BITS-1:0] t_ctr;
    typedef logic [HIST_W-1:0]       t_hist;
    typedef logic [TAG_W-1:0]        t_tag;
    typedef logic [2*TAG_W-1:0]      t_tag_pair;
    typedef logic [SET_W-1:0]        t_set;
    typedef logic [CACHE_IDX_W-1:0]  t_gidx;
    typedef logic [CHOICE_IDX_W-1:0] t_cidx;
    typedef logic [TID_W-1:0]        t_tid;

    // One result item, prediction in the lowest bit.
    typedef struct packed {
        logic [SOURCE_W-1:0]     source_out;
        logic                    choice_out;
        logic [HIST_FIELD_W-1:0] history_out;
        logic                    prediction;
    } t_result;

    // Write-back of one exception cache.
    typedef struct packed {
        logic      tags_we;
        t_tag_pair tags;
        logic      lru_we;
        logic      lru;
        logic      ctr_we;
        t_ctr      ctr;
    } t_cache_wr;

    // Item held in the table stage.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        t_tid                tid;
        t_tag                tag;
        t_set                set;
        t_gidx               gidx;
        t_cidx               cidx;
        t_hist               prior_hist;
        logic                outcome;
        logic                squashed;
        t_hist               saved_hist;
        logic                saved_choice;
        logic [SOURCE_W-1:0] saved_src;
        logic                saved_final;
    } t_stage;

    // Saturating step toward the outcome.
    function automatic t_ctr ctr_move(input t_ctr c, input logic up);
        t_ctr r;
        r = c;
        if (up) begin
            if (c != '1) r = c + t_ctr'(1);
        end else begin
            if (c != '0) r = c - t_ctr'(1);
        end
        return r;
    endfunction

    // A counter predicts taken when it is above the midpoint.
    function automatic logic ctr_taken(input t_ctr c);
        return c[COUNTER_BITS-1];
    endfunction

    // Fold the thread field into the implemented thread range.
    function automatic t_tid thread_slot(input logic [THREAD_FIELD_W-1:0] tid);
        logic [THREAD_FIELD_W-1:0] t;
        t = tid;
        for (int k = 0; k < (1 << THREAD_FIELD_W); k++) begin
            if (int'(t) >= THREADS) t = t - THREAD_FIELD_W'(THREADS);
        end
        return t_tid'(t);
    endfunction

endpackage

`default_nettype wire

// ----- design/ybp_ram.sv -----
`default_nettype none

// Simple dual-port RAM with registered read and same-edge write bypass.
module ybp_ram #(
    parameter int W  = 2,
    parameter int AW = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [2**AW];
    logic [W-1:0] r_rdata;
    logic [W-1:0] r_wdata;
    logic         r_bypass;

    // Write port, read port, and capture of a write to the address being read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata  <= r_mem[i_raddr];
        r_bypass <= i_we && (i_waddr == i_raddr);
        r_wdata  <= i_wdata;
    end

    // The newest data wins when the read collided with a write.
    assign o_rdata = r_bypass ? r_wdata : r_rdata;

endmodule

`default_nettype wire

// ----- design/ybp_xcache.sv -----
`default_nettype none

// Probe and training logic for one exception cache set.
module ybp_xcache
    import ybp_pkg::*;
(
    input  t_tag      i_tag,
    input  t_tag_pair i_tags,
    input  logic      i_lru,
    input  t_ctr      i_ctr,
    input  logic      i_outcome,
    input  logic      i_probe,
    input  logic      i_train,
    output logic      o_hit,
    output logic      o_ctr_taken,
    output t_cache_wr o_wr
);

    logic hit0;
    logic hit1;
    logic lru_fill;
    t_ctr ctr_new;

    // Way 0 wins when both ways hold the tag.
    assign hit0  = (i_tags[TAG_W-1:0] == i_tag);
    assign hit1  = (i_tags[2*TAG_W-1:TAG_W] == i_tag);
    assign o_hit = hit0 || hit1;
    assign o_ctr_taken = ctr_taken(i_ctr);

    assign ctr_new = ctr_move(i_ctr, i_outcome);

    // On a hit the LRU points away from the hit way; on a miss it points to the other way.
    assign lru_fill = o_hit ? !hit0 : !i_lru;

    always_comb begin
        o_wr.tags_we = i_train && !o_hit;
        o_wr.tags    = i_lru ? {i_tags[2*TAG_W-1:TAG_W], i_tag}
                             : {i_tag, i_tags[TAG_W-1:0]};
        o_wr.ctr_we  = i_train;
        o_wr.ctr     = ctr_new;
        o_wr.lru_we  = i_train || (i_probe && o_hit);
        if (i_train) begin
            // A counter that ends predicting not taken flips the replacement choice.
            o_wr.lru = ctr_taken(ctr_new) ? lru_fill : !lru_fill;
        end else begin
            o_wr.lru = !hit0;
        end
    end

endmodule

`default_nettype wire

// ----- design/ybp_out_queue.sv -----
`default_nettype none

// Small result queue that decouples the table stage from the output handshake.
module ybp_out_queue
    import ybp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_result              i_data,
    output logic                 o_tvalid,
    input  logic                 i_tready,
    output t_result              o_data,
    output logic [OUT_CNT_W-1:0] o_count
);

    t_result              r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_count;
    logic [OUT_CNT_W-1:0] n_count;
    logic                 pop;

    assign o_tvalid = (r_count != '0);
    assign o_data   = r_mem[r_rd_ptr];
    assign o_count  = r_count;
    assign pop      = o_tvalid && i_tready;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + OUT_CNT_W'(1);
        end else if (!i_push && pop) begin
            n_count = r_count - OUT_CNT_W'(1);
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + OUT_PTR_W'(1);
            if (pop)    r_rd_ptr <= r_rd_ptr + OUT_PTR_W'(1);
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/yags_branch_predictor.sv -----
`default_nettype none
// An accepted item is registered in the table stage, then pushed into the result
// queue, from which it is offered on the result port.
// Throughput: one item per cycle while the result queue has room; each item makes
// one read-modify-write pass over the tables, with same-edge bypass in every RAM
// and history forwarding. Reset: synchronous, active low; afterwards a clearing
// pass fills the tables with their initial values while tready stays low.
module yags_branch_predictor
    import ybp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // thread, branch_address, outcome, squashed, saved_history, saved_choice,
    // saved_source, saved_final, zero fill
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // action
    input  logic [ACTION_W-1:0]  i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // prediction, history_out, choice_out, source_out, zero fill
    output logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    // Input fields.
    logic [ACTION_W-1:0]       s_action;
    logic [THREAD_FIELD_W-1:0] s_thread;
    logic [ADDR_W-1:0]         s_addr;
    logic                      s_outcome;
    logic                      s_squashed;
    logic [HIST_FIELD_W-1:0]   s_saved_hist;
    logic                      s_saved_choice;
    logic [SOURCE_W-1:0]       s_saved_src;
    logic                      s_saved_final;

    assign s_action       = i_s_axis_tuser;
    assign s_thread       = i_s_axis_tdata[1:0];
    assign s_addr         = i_s_axis_tdata[33:2];
    assign s_outcome      = i_s_axis_tdata[34];
    assign s_squashed     = i_s_axis_tdata[35];
    assign s_saved_hist   = i_s_axis_tdata[46:36];
    assign s_saved_choice = i_s_axis_tdata[47];
    assign s_saved_src    = i_s_axis_tdata[49:48];
    assign s_saved_final  = i_s_axis_tdata[50];

    logic                 accept;
    logic                 r_clearing;
    logic [CLR_W-1:0]     r_clr;
    logic                 r_v1;
    t_stage               r_st;
    t_stage               n_st;
    t_hist                r_hist [THREADS];
    logic [OUT_CNT_W-1:0] q_count;
    t_result              q_data;

    // Table stage signals.
    t_ctr      choice_q;
    t_ctr      tctr_q;
    t_ctr      ntctr_q;
    t_tag_pair ttags_q;
    t_tag_pair nttags_q;
    logic      tlru_q;
    logic      ntlru_q;
    logic      is_lookup;
    logic      is_update;
    logic      ch;
    logic      upd_t;
    logic      upd_nt;
    logic      t_hit;
    logic      nt_hit;
    logic      t_ctr_taken;
    logic      nt_ctr_taken;
    t_cache_wr t_wr;
    t_cache_wr nt_wr;
    logic      fin;
    logic [SOURCE_W-1:0] src;
    logic      move_choice;
    logic      choice_we;
    logic      hist_we;
    t_hist     hist_next;
    t_result   result;

    // Accept-side signals.
    t_tid  s_tid;
    t_hist cur_hist;
    t_hist s_h;

    assign o_s_axis_tready = !r_clearing &&
                             ((q_count + OUT_CNT_W'(r_v1)) < OUT_CNT_W'(OUT_DEPTH));
    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    // Lookup and training decisions for the item in the table stage.
    assign is_lookup = r_v1 && (r_st.action == ACT_LOOKUP);
    assign is_update = r_v1 && (r_st.action == ACT_UPDATE);
    assign ch        = ctr_taken(choice_q);
    assign upd_t     = (!r_st.saved_choice && r_st.outcome) || (r_st.saved_src == SRC_TAKEN);
    assign upd_nt    = (r_st.saved_choice && !r_st.outcome) || (r_st.saved_src == SRC_NOT_TAKEN);

    ybp_xcache u_taken (
        .i_tag       (r_st.tag),
        .i_tags      (ttags_q),
        .i_lru       (tlru_q),
        .i_ctr       (tctr_q),
        .i_outcome   (r_st.outcome),
        .i_probe     (is_lookup && !ch),
        .i_train     (is_update && upd_t),
        .o_hit       (t_hit),
        .o_ctr_taken (t_ctr_taken),
        .o_wr        (t_wr)
    );

    ybp_xcache u_not_taken (
        .i_tag       (r_st.tag),
        .i_tags      (nttags_q),
        .i_lru       (ntlru_q),
        .i_ctr       (ntctr_q),
        .i_outcome   (r_st.outcome),
        .i_probe     (is_lookup && ch),
        .i_train     (is_update && upd_nt),
        .o_hit       (nt_hit),
        .o_ctr_taken (nt_ctr_taken),
        .o_wr        (nt_wr)
    );

    // Final prediction: the opposite cache overrides the choice on a tag hit.
    always_comb begin
        fin = ch;
        src = SRC_CHOICE;
        if (ch && nt_hit) begin
            fin = nt_ctr_taken;
            src = SRC_NOT_TAKEN;
        end else if (!ch && t_hit) begin
            fin = t_ctr_taken;
            src = SRC_TAKEN;
        end
    end

    // The choice counter trains on a mispredict or a right call in a cache's own direction.
    always_comb begin
        if (r_st.saved_final == r_st.outcome) begin
            move_choice = (r_st.saved_final && (r_st.saved_src == SRC_TAKEN)) ||
                          (!r_st.saved_final && (r_st.saved_src == SRC_NOT_TAKEN));
        end else begin
            move_choice = 1'b1;
        end
    end
    assign choice_we = is_update && move_choice;

    // History update and result for each action.
    always_comb begin
        hist_we            = 1'b0;
        hist_next          = r_st.prior_hist;
        result.prediction  = 1'b0;
        result.choice_out  = 1'b0;
        result.source_out  = SRC_CHOICE;
        result.history_out = HIST_FIELD_W'(r_st.prior_hist);
        unique case (r_st.action)
            ACT_LOOKUP: begin
                hist_we           = 1'b1;
                hist_next         = {r_st.prior_hist[HIST_W-2:0], fin};
                result.prediction = fin;
                result.choice_out = ch;
                result.source_out = src;
            end
            ACT_UNCOND: begin
                hist_we           = 1'b1;
                hist_next         = {r_st.prior_hist[HIST_W-2:0], 1'b1};
                result.prediction = 1'b1;
                result.choice_out = 1'b1;
            end
            ACT_UPDATE: begin
                hist_we   = r_st.squashed;
                hist_next = {r_st.saved_hist[HIST_W-2:0], r_st.outcome};
            end
            ACT_RESTORE: begin
                hist_we   = 1'b1;
                hist_next = r_st.saved_hist;
            end
            ACT_BTB_MISS: begin
                hist_we   = 1'b1;
                hist_next = {r_st.prior_hist[HIST_W-1:1], 1'b0};
            end
            default: begin
                hist_we = 1'b0;
            end
        endcase
    end

    // History seen by the incoming item, forwarded from the table stage.
    assign s_tid    = thread_slot(s_thread);
    assign cur_hist = (r_v1 && hist_we && (r_st.tid == s_tid)) ? hist_next : r_hist[s_tid];
    assign s_h      = (s_action == ACT_LOOKUP) ? cur_hist : t_hist'(s_saved_hist);

    // Table indexes and carried fields of the incoming item.
    always_comb begin
        n_st.action       = s_action;
        n_st.tid          = s_tid;
        n_st.tag          = s_addr[INSTRUCTION_SHIFT+TAG_SKIP +: TAG_W];
        n_st.set          = s_addr[INSTRUCTION_SHIFT+1 +: SET_W] ^ s_h[SET_W-1:0];
        n_st.gidx         = s_addr[INSTRUCTION_SHIFT +: CACHE_IDX_W] ^ s_h;
        n_st.cidx         = s_addr[INSTRUCTION_SHIFT +: CHOICE_IDX_W];
        n_st.prior_hist   = cur_hist;
        n_st.outcome      = s_outcome;
        n_st.squashed     = s_squashed;
        n_st.saved_hist   = t_hist'(s_saved_hist);
        n_st.saved_choice = s_saved_choice;
        n_st.saved_src    = s_saved_src;
        n_st.saved_final  = s_saved_final;
    end

    // Tables; the clearing pass owns the write ports after reset.
    ybp_ram #(.W(COUNTER_BITS), .AW(CHOICE_IDX_W)) u_choice_ram (
        .i_clk   (i_clk),
        .i_we    (r_clearing || choice_we),
        .i_waddr (r_clearing ? r_clr[CHOICE_IDX_W-1:0] : r_st.cidx),
        .i_wdata (r_clearing ? t_ctr'(0) : ctr_move(choice_q, r_st.outcome)),
        .i_raddr (n_st.cidx),
        .o_rdata (choice_q)
    );

    ybp_ram #(.W(COUNTER_BITS), .AW(CACHE_IDX_W)) u_tctr_ram (
        .i_clk   (i_clk),
        .i_we    (r_clearing || t_wr.ctr_we),
        .i_waddr (r_clearing ? r_clr[CACHE_IDX_W-1:0] : r_st.gidx),
        .i_wdata (r_clearing ? t_ctr'(0) : t_wr.ctr),
        .i_raddr (n_st.gidx),
        .o_rdata (tctr_q)
    );

    ybp_ram #(.W(COUNTER_BITS), .AW(CACHE_IDX_W)) u_ntctr_ram (
        .i_clk   (i_clk),
        .i_we    (r_clearing || nt_wr.ctr_we),
        .i_waddr (r_clearing ? r_clr[CACHE_IDX_W-1:0] : r_st.gidx),
        .i_wdata (r_clearing ? t_ctr'(0) : nt_wr.ctr),
        .i_raddr (n_st.gidx),
        .o_rdata (ntctr_q)
    );

    ybp_ram #(.W(2*TAG_W), .AW(SET_W)) u_ttag_ram (
        .i_clk   (i_clk),
        .i_we    (r_clearing || t_wr.tags_we),
        .i_waddr (r_clearing ? r_clr[SET_W-1:0] : r_st.set),
        .i_wdata (r_clearing ? t_tag_pair'(0) : t_wr.tags),
        .i_raddr (n_st.set),
        .o_rdata (ttags_q)
    );

    ybp_ram #(.W(2*TAG_W), .AW(SET_W)) u_nttag_ram (
        .i_clk   (i_clk),
        .i_we    (r_clearing || nt_wr.tags_we),
        .i_waddr (r_clearing ? r_clr[SET_W-1:0] : r_st.set),
        .i_wdata (r_clearing ? t_tag_pair'(0) : nt_wr.tags),
        .i_raddr (n_st.set),
        .o_rdata (nttags_q)
    );

    ybp_ram #(.W(1), .AW(SET_W)) u_tlru_ram (
        .i_clk   (i_clk),
        .i_we    (r_clearing || t_wr.lru_we),
        .i_waddr (r_clearing ? r_clr[SET_W-1:0] : r_st.set),
        .i_wdata (r_clearing ? 1'b1 : t_wr.lru),
        .i_raddr (n_st.set),
        .o_rdata (tlru_q)
    );

    ybp_ram #(.W(1), .AW(SET_W)) u_ntlru_ram (
        .i_clk   (i_clk),
        .i_we    (r_clearing || nt_wr.lru_we),
        .i_waddr (r_clearing ? r_clr[SET_W-1:0] : r_st.set),
        .i_wdata (r_clearing ? 1'b1 : nt_wr.lru),
        .i_raddr (n_st.set),
        .o_rdata (ntlru_q)
    );

    // Clearing pass after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr      <= '0;
        end else if (r_clearing) begin
            r_clr <= r_clr + CLR_W'(1);
            if (r_clr == '1) r_clearing <= 1'b0;
        end
    end

    // Table stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_st <= n_st;
    end

    // Per-thread global history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < THREADS; k++) r_hist[k] <= '0;
        end else if (r_v1 && hist_we) begin
            r_hist[r_st.tid] <= hist_next;
        end
    end

    // Results wait here for the output handshake.
    ybp_out_queue u_out_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (r_v1),
        .i_data   (result),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_data   (q_data),
        .o_count  (q_count)
    );

    assign o_m_axis_tdata = {(M_TDATA_W - $bits(t_result))'(0), q_data};

endmodule

`default_nettype wire

// ----- design/ybp_checker.sv -----
`default_nettype none

// Port-level checks for the predictor.
module ybp_checker
    import ybp_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic [S_TDATA_W-1:0] i_s_axis_tdata,
    input logic [ACTION_W-1:0]  i_s_axis_tuser,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    logic [3:0] r_inflight;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;

    // Items accepted but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 4'(in_acc) - 4'(out_acc);
        end
    end

    // The clearing pass holds off input right after reset.
    a_clear_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> !o_s_axis_tready)
        else $error("input accepted during the clearing pass");

    // No result appears without an item behind it.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_inflight != '0))
        else $error("result item without an accepted item");

    // The pipeline plus queue never holds more than its capacity.
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight >= 4'(OUT_DEPTH)) |-> !o_s_axis_tready)
        else $error("input accepted with no room for its result");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result item changed");

endmodule

bind yags_branch_predictor ybp_checker u_ybp_checker (.*);

`default_nettype wire
